// File: src/dod_pkg.sv
// Shared types, register codes and reset values for the door open/close detector.
package dod_pkg;

	localparam int unsigned YAW_W   = 16;
	localparam int unsigned ACC_W   = 16;
	localparam int unsigned TICK_W  = 32;
	localparam int unsigned THR_W   = 15;
	localparam int unsigned SQ_W    = 32;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;

	typedef enum logic [1:0] {
		PH_CLOSED = 2'd0,
		PH_OPEN   = 2'd1,
		PH_CAND   = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPEN_YAW      = 3'd0,
		CFG_CLOSE_YAW     = 3'd1,
		CFG_STILL_YAW     = 3'd2,
		CFG_ACCEL_SQ_LOW  = 3'd3,
		CFG_ACCEL_SQ_HIGH = 3'd4,
		CFG_SETTLE_TICKS  = 3'd5,
		CFG_STATIC_NEEDED = 3'd6
	} cfg_idx_t;

	localparam logic [THR_W-1:0]  RST_OPEN_YAW      = 15'd1430;
	localparam logic [THR_W-1:0]  RST_CLOSE_YAW     = 15'd1072;
	localparam logic [THR_W-1:0]  RST_STILL_YAW     = 15'd36;
	localparam logic [SQ_W-1:0]   RST_ACCEL_SQ_LOW  = 32'd60565749;
	localparam logic [SQ_W-1:0]   RST_ACCEL_SQ_HIGH = 32'd73987522;
	localparam logic [TICK_W-1:0] RST_SETTLE_TICKS  = 32'd1000;
	localparam logic [CNT_W-1:0]  RST_STATIC_NEEDED = 6'd50;

	typedef struct packed {
		logic [THR_W-1:0]  open_yaw;
		logic [THR_W-1:0]  close_yaw;
		logic [THR_W-1:0]  still_yaw;
		logic [SQ_W-1:0]   accel_sq_low;
		logic [SQ_W-1:0]   accel_sq_high;
		logic [TICK_W-1:0] settle_ticks;
		logic [CNT_W-1:0]  static_needed;
	} cfg_t;

	// One sample out of the input register, with its at-rest flag, ready for
	// the phase logic.
	typedef struct packed {
		logic                     valid;
		logic signed [YAW_W-1:0]  yaw;
		logic [TICK_W-1:0]        now_ticks;
		logic                     session_end;
		logic                     at_rest;
	} item_t;

endpackage

// File: src/dod_cfg.sv
// Configuration register file of the door open/close detector.
module dod_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dod_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dod_pkg::CFG_DAT_W-1:0]    cfg_data,
	output dod_pkg::cfg_t                    cfg
);
	import dod_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Writes to an index past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_yaw      <= RST_OPEN_YAW;
			cfg_q.close_yaw     <= RST_CLOSE_YAW;
			cfg_q.still_yaw     <= RST_STILL_YAW;
			cfg_q.accel_sq_low  <= RST_ACCEL_SQ_LOW;
			cfg_q.accel_sq_high <= RST_ACCEL_SQ_HIGH;
			cfg_q.settle_ticks  <= RST_SETTLE_TICKS;
			cfg_q.static_needed <= RST_STATIC_NEEDED;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OPEN_YAW:      cfg_q.open_yaw      <= cfg_data[THR_W-1:0];
				CFG_CLOSE_YAW:     cfg_q.close_yaw     <= cfg_data[THR_W-1:0];
				CFG_STILL_YAW:     cfg_q.still_yaw     <= cfg_data[THR_W-1:0];
				CFG_ACCEL_SQ_LOW:  cfg_q.accel_sq_low  <= cfg_data[SQ_W-1:0];
				CFG_ACCEL_SQ_HIGH: cfg_q.accel_sq_high <= cfg_data[SQ_W-1:0];
				CFG_SETTLE_TICKS:  cfg_q.settle_ticks  <= cfg_data[TICK_W-1:0];
				CFG_STATIC_NEEDED: cfg_q.static_needed <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: src/dod_mag.sv
// Input register and squared-acceleration window check that yields the at-rest flag.
module dod_mag (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [dod_pkg::YAW_W-1:0]    yaw,
	input  logic signed [dod_pkg::ACC_W-1:0]    accel_x,
	input  logic signed [dod_pkg::ACC_W-1:0]    accel_y,
	input  logic signed [dod_pkg::ACC_W-1:0]    accel_z,
	input  logic [dod_pkg::TICK_W-1:0]          now_ticks,
	input  logic                                session_end,
	input  dod_pkg::cfg_t                       cfg,
	output dod_pkg::item_t                      item
);
	import dod_pkg::*;

	logic                    v_s1;
	logic signed [YAW_W-1:0] yaw_s1;
	logic signed [ACC_W-1:0] ax_s1, ay_s1, az_s1;
	logic [TICK_W-1:0]       now_s1;
	logic                    req_s1;
	logic [ACC_W-1:0]        mag_x, mag_y, mag_z;
	logic [SQ_W-1:0]         sq_x, sq_y, sq_z;
	logic [SQ_W-1:0]         sum_sq;
	logic                    at_rest;

	// |-32768| still fits 16 unsigned bits.
	function automatic logic [ACC_W-1:0] mag16(input logic signed [ACC_W-1:0] a);
		mag16 = a[ACC_W-1] ? (~a + 1'b1) : a;
	endfunction

	assign mag_x = mag16(ax_s1);
	assign mag_y = mag16(ay_s1);
	assign mag_z = mag16(az_s1);

	assign sq_x = SQ_W'(mag_x) * SQ_W'(mag_x);
	assign sq_y = SQ_W'(mag_y) * SQ_W'(mag_y);
	assign sq_z = SQ_W'(mag_z) * SQ_W'(mag_z);

	// Three squares of at most 2^30 cannot overflow 32 bits.
	assign sum_sq  = sq_x + sq_y + sq_z;
	assign at_rest = (sum_sq > cfg.accel_sq_low) && (sum_sq < cfg.accel_sq_high);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s1 <= yaw;
			now_s1 <= now_ticks;
			req_s1 <= session_end;
			ax_s1  <= accel_x;
			ay_s1  <= accel_y;
			az_s1  <= accel_z;
		end
	end

	assign item.valid       = v_s1;
	assign item.yaw         = yaw_s1;
	assign item.now_ticks   = now_s1;
	assign item.session_end = req_s1;
	assign item.at_rest     = at_rest;

endmodule

// File: src/dod_fsm.sv
// Door phase machine with session-end handling and the result register.
module dod_fsm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  dod_pkg::item_t               item,
	input  dod_pkg::cfg_t                cfg,
	output logic                         out_valid,
	output logic [1:0]                   door_status,
	output logic                         opened_event,
	output logic                         closed_event
);
	import dod_pkg::*;

	phase_t                  phase_q, phase_d;
	logic [TICK_W-1:0]       cand_time_q, cand_time_d;
	logic signed [YAW_W-1:0] cand_yaw_q, cand_yaw_d;
	logic [CNT_W-1:0]        rest_cnt_q, rest_cnt_d;
	logic                    end_pend_q, end_pend_d;
	logic                    opened_d, closed_d;

	logic                    out_valid_q;
	phase_t                  state_q;
	logic                    opened_q, closed_q;

	logic                    step;
	assign step = en && item.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CLOSED;
			cand_time_q <= '0;
			cand_yaw_q  <= '0;
			rest_cnt_q  <= '0;
			end_pend_q  <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			cand_time_q <= cand_time_d;
			cand_yaw_q  <= cand_yaw_d;
			rest_cnt_q  <= rest_cnt_d;
			end_pend_q  <= end_pend_d;
		end
	end

	always_comb begin
		logic [CNT_W-1:0]  cnt_base;
		logic [CNT_W-1:0]  cnt_inc;
		logic              pend;
		logic signed [YAW_W:0] diff;
		logic [YAW_W:0]    drift;
		logic [TICK_W-1:0] dt;
		logic              still;
		logic signed [YAW_W-1:0] open_thr;
		logic signed [YAW_W-1:0] close_thr;

		phase_d     = phase_q;
		cand_time_d = cand_time_q;
		cand_yaw_d  = cand_yaw_q;
		opened_d    = 1'b0;
		closed_d    = 1'b0;

		// A new request clears the count once; a held request leaves it alone.
		cnt_base = (item.session_end && !end_pend_q) ? '0 : rest_cnt_q;
		pend     = end_pend_q || item.session_end;
		cnt_inc  = cnt_base + 1'b1;
		rest_cnt_d = cnt_base;
		end_pend_d = pend;

		open_thr  = $signed({1'b0, cfg.open_yaw});
		close_thr = $signed({1'b0, cfg.close_yaw});
		diff  = $signed({item.yaw[YAW_W-1], item.yaw})
			- $signed({cand_yaw_q[YAW_W-1], cand_yaw_q});
		drift = diff[YAW_W] ? (~diff + 1'b1) : diff;
		dt    = item.now_ticks - cand_time_q;
		still = drift < {2'b00, cfg.still_yaw};

		if (pend && phase_q != PH_CLOSED) begin
			// Forced close: count consecutive at-rest samples, yaw is ignored.
			if (item.at_rest) begin
				rest_cnt_d = cnt_inc;
				if (cnt_inc >= cfg.static_needed) begin
					phase_d    = PH_CLOSED;
					closed_d   = 1'b1;
					rest_cnt_d = '0;
					end_pend_d = 1'b0;
				end
			end else begin
				rest_cnt_d = '0;
			end
		end else begin
			end_pend_d = 1'b0;
			case (phase_q)
				PH_OPEN: begin
					if (item.yaw < close_thr) begin
						phase_d     = PH_CAND;
						cand_time_d = item.now_ticks;
						cand_yaw_d  = item.yaw;
					end
				end
				PH_CAND: begin
					if (item.yaw > close_thr) begin
						phase_d = PH_OPEN;
					end else if (item.at_rest && still && dt >= cfg.settle_ticks) begin
						phase_d  = PH_CLOSED;
						closed_d = 1'b1;
					end else if (!item.at_rest || !still) begin
						cand_time_d = item.now_ticks;
						cand_yaw_d  = item.yaw;
					end
				end
				default: begin
					if (item.yaw > open_thr) begin
						phase_d  = PH_OPEN;
						opened_d = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			state_q  <= phase_d;
			opened_q <= opened_d;
			closed_q <= closed_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign door_status  = state_q;
	assign opened_event = opened_q;
	assign closed_event = closed_q;

	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(opened_q && closed_q))
		else $error("open and close events on the same word");

	a_opened_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && opened_q) |-> (state_q == PH_OPEN && phase_q == PH_OPEN))
		else $error("open event without open state");

	a_closed_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && closed_d) |=> (phase_q == PH_CLOSED && !end_pend_q && rest_cnt_q == '0))
		else $error("close did not clear session-end tracking");

	a_pending_not_closed: assert property (@(posedge clk) disable iff (!arst_n)
		end_pend_q |-> (phase_q != PH_CLOSED))
		else $error("session end pending while closed");

endmodule

// File: src/door_open_close_detector_top.sv
// Top level of the door open/close detector.
//
// Input channel: one word per accepted sample (yaw, accel_x/y/z, now_ticks,
// session_end), taken at a rising edge where in_valid is high and in_stall
// is low. Output channel: one result word per sample (door_status,
// opened_event, closed_event), taken where out_valid is high and out_stall
// is low. Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and unknown indexes are ignored.
// The accepting edge loads the input register, and the result register is
// then written from the squaring, window compare and phase logic that sit
// between the two registers. Throughput is one word per cycle while no
// result is held back; the phase state is updated in that same pass, so
// back-to-back samples see each other's updates. Both registers advance
// together; they freeze only while a result waits and out_stall is high,
// which is also exactly when in_stall is high.
// Reset clears the valid bits, the phase (closed), the candidate
// time and yaw, the rest counter and the pending session end, and loads
// the default thresholds into the configuration registers.
module door_open_close_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [dod_pkg::YAW_W-1:0]    yaw,
	input  logic signed [dod_pkg::ACC_W-1:0]    accel_x,
	input  logic signed [dod_pkg::ACC_W-1:0]    accel_y,
	input  logic signed [dod_pkg::ACC_W-1:0]    accel_z,
	input  logic [dod_pkg::TICK_W-1:0]          now_ticks,
	input  logic                                session_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          door_status,
	output logic                                opened_event,
	output logic                                closed_event,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dod_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dod_pkg::CFG_DAT_W-1:0]       cfg_data
);
	import dod_pkg::*;

	cfg_t  cfg;
	item_t item;
	logic  en;

	// Everything moves unless a finished word is being held back.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	dod_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dod_mag u_mag (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.yaw         (yaw),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.now_ticks   (now_ticks),
		.session_end (session_end),
		.cfg         (cfg),
		.item        (item)
	);

	dod_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.item         (item),
		.cfg          (cfg),
		.out_valid    (out_valid),
		.door_status  (door_status),
		.opened_event (opened_event),
		.closed_event (closed_event)
	);

endmodule

// File: verif/door_open_close_detector_top_tb.sv
// Self-checking testbench for the door open/close detector top level.
module door_open_close_detector_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dod_pkg::*;

	// Clock and reset timing. The drain leaves the block idle after the last
	// result word has been taken.
	localparam int RESET_CYCLES    = 8;
	localparam int PIPE_DRAIN      = 8;
	localparam int LONG_HOLD       = 40;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 78;
	localparam int NUM_PHASES      = 9;

	// An index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	// One g on a single axis in Q2.13, and its square in Q6.26.
	localparam logic signed [ACC_W-1:0] ONE_G    = 16'sd8192;
	localparam logic [SQ_W-1:0]         ONE_G_SQ = 32'd67108864;

	typedef struct packed {
		logic signed [YAW_W-1:0] yaw;
		logic signed [ACC_W-1:0] ax;
		logic signed [ACC_W-1:0] ay;
		logic signed [ACC_W-1:0] az;
		logic [TICK_W-1:0]       now;
		logic                    se;
	} sample_t;

	localparam int SAMPLE_W = $bits(sample_t);

	typedef struct packed {
		logic [1:0] state;
		logic       opened;
		logic       closed;
	} door_result_t;

	typedef struct packed {
		sample_t      s;
		logic         typed;
		door_result_t r;
	} directed_row_t;

	// Threshold settings used by the random phases.
	typedef enum {
		PLAN_WANDER,
		PLAN_GENTLE,
		PLAN_ALL_MAX,
		PLAN_ALL_ZERO,
		PLAN_EDGE_WINDOW,
		PLAN_INVERTED,
		PLAN_NO_COUNT
	} cfg_plan_t;

	// Kinds of motion segment for the random sample generator.
	typedef enum {
		SEG_CALM,
		SEG_SWING,
		SEG_BUMPY,
		SEG_NOISE
	} motion_t;

	localparam cfg_plan_t PHASE_PLAN [NUM_PHASES] = '{
		PLAN_WANDER, PLAN_GENTLE, PLAN_ALL_MAX, PLAN_ALL_ZERO, PLAN_EDGE_WINDOW,
		PLAN_INVERTED, PLAN_NO_COUNT, PLAN_WANDER, PLAN_GENTLE
	};

	// Directed walk under the reset thresholds. Each row is yaw, accel x/y/z,
	// ticks and session end, then whether the expected word is typed in, then
	// state, opened and closed. Untyped rows are checked against the predictor.
	localparam int DIR_ROWS = 23;
	localparam directed_row_t DIR_TABLE [DIR_ROWS] = '{
		// Straight after reset: closed, no motion.
		'{'{0, 0, 0, 0, 0, 0}, 1, '{PH_CLOSED, 0, 0}},
		// Every field at its low extreme, ticks at the top of the range.
		'{'{-32768, -32768, -32768, -32768, 32'hFFFF_FFFF, 0}, 1, '{PH_CLOSED, 0, 0}},
		// Yaw and every accel axis at its high extreme: the door swings open.
		'{'{32767, 32767, 32767, 32767, 0, 0}, 1, '{PH_OPEN, 1, 0}},
		// Yaw exactly at the open threshold while open, then a closing candidate.
		'{'{1430, 8192, 0, 0, 50, 0}, 0, '0},
		'{'{1000, 8192, 0, 0, 100, 0}, 0, '0},
		'{'{1005, 8192, 0, 0, 600, 0}, 0, '0},
		// Settle time reached while still and at rest: closed.
		'{'{1010, 0, 8192, 0, 1100, 0}, 0, '0},
		// One above the open threshold, then either side of the close threshold.
		'{'{1431, 0, 0, 8192, 1200, 0}, 0, '0},
		'{'{1071, 8192, 0, 0, 1300, 0}, 0, '0},
		'{'{1073, 8192, 0, 0, 1400, 0}, 0, '0},
		// A bump and then too much yaw drift both restart the candidate.
		'{'{500, -8192, 0, 0, 1500, 0}, 0, '0},
		'{'{520, 16384, 0, 0, 1600, 0}, 0, '0},
		'{'{560, 8192, 0, 0, 2500, 0}, 0, '0},
		'{'{570, 8192, 0, 0, 3499, 0}, 0, '0},
		'{'{570, 8192, 0, 0, 3500, 0}, 0, '0},
		// Session end while closed is dropped and the door still opens.
		'{'{2000, 8192, 0, 0, 3600, 1}, 0, '0},
		// A candidate that straddles the tick wrap closes after exactly the settle time.
		'{'{1000, 8192, 0, 0, 32'hFFFF_FF00, 0}, 0, '0},
		'{'{1000, 8192, 0, 0, 32'h0000_02E8, 0}, 0, '0},
		// Session end while open: a bump clears the count, a held request does not.
		'{'{2000, 8192, 0, 0, 32'h0000_0300, 0}, 0, '0},
		'{'{2000, 16384, 0, 0, 32'h0000_0310, 1}, 0, '0},
		'{'{100, 8192, 0, 0, 32'h0000_0320, 0}, 0, '0},
		'{'{100, 8192, 0, 0, 32'h0000_0330, 1}, 0, '0},
		'{'{100, -32768, 0, 0, 32'h0000_0340, 0}, 0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [YAW_W-1:0] yaw;
	logic signed [ACC_W-1:0] accel_x;
	logic signed [ACC_W-1:0] accel_y;
	logic signed [ACC_W-1:0] accel_z;
	logic [TICK_W-1:0] now_ticks;
	logic session_end;
	logic out_valid;
	logic out_stall;
	logic [1:0] door_status;
	logic opened_event;
	logic closed_event;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// Predictor state: its own copy of the thresholds and of the door machine.
	cfg_t thr;
	phase_t door_phase;
	logic [TICK_W-1:0] cand_ticks;
	logic signed [YAW_W-1:0] cand_yaw;
	logic [CNT_W-1:0] rest_run;
	logic end_req;

	// Result words still owed by the block, oldest first.
	door_result_t expected_results[$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int src_idle_pct;
	int sink_idle_pct;
	int stall_left = 0;
	logic hold_off_req;

	door_open_close_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.yaw          (yaw),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.now_ticks    (now_ticks),
		.session_end  (session_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.door_status  (door_status),
		.opened_event (opened_event),
		.closed_event (closed_event),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Runaway guard: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d result words outstanding", $time,
				expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Door machine predictor. It advances the predictor state by one sample and
	// returns the result word the block must produce for it.
	function automatic door_result_t door_predict(sample_t s);
		longint mag_sq;
		int drift;
		logic [TICK_W-1:0] elapsed;
		logic at_rest;
		logic still;
		door_result_t r;

		mag_sq = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
		// Both bounds are exclusive, so an inverted or empty window never holds.
		at_rest = (mag_sq > longint'(thr.accel_sq_low)) && (mag_sq < longint'(thr.accel_sq_high));
		r.opened = 1'b0;
		r.closed = 1'b0;

		// The request latches; the count restarts only on a fresh request.
		if (s.se) begin
			if (!end_req)
				rest_run = '0;
			end_req = 1'b1;
		end

		if (end_req && door_phase != PH_CLOSED) begin
			// Pending session end overrides the yaw machine entirely.
			if (at_rest) begin
				rest_run = rest_run + 1'b1;
				if (rest_run >= thr.static_needed) begin
					door_phase = PH_CLOSED;
					r.closed = 1'b1;
					rest_run = '0;
					end_req = 1'b0;
				end
			end else begin
				rest_run = '0;
			end
		end else begin
			// A request seen while closed is simply dropped.
			end_req = 1'b0;
			case (door_phase)
				PH_CLOSED: begin
					if (int'(s.yaw) > int'(thr.open_yaw)) begin
						door_phase = PH_OPEN;
						r.opened = 1'b1;
					end
				end
				PH_OPEN: begin
					if (int'(s.yaw) < int'(thr.close_yaw)) begin
						door_phase = PH_CAND;
						cand_ticks = s.now;
						cand_yaw = s.yaw;
					end
				end
				default: begin
					if (int'(s.yaw) > int'(thr.close_yaw)) begin
						door_phase = PH_OPEN;
					end else begin
						drift = int'(s.yaw) - int'(cand_yaw);
						if (drift < 0)
							drift = -drift;
						still = drift < int'(thr.still_yaw);
						elapsed = s.now - cand_ticks;
						if (at_rest && still && elapsed >= thr.settle_ticks) begin
							door_phase = PH_CLOSED;
							r.closed = 1'b1;
						end else if (!at_rest || !still) begin
							cand_ticks = s.now;
							cand_yaw = s.yaw;
						end
					end
				end
			endcase
		end

		r.state = door_phase;
		return r;
	endfunction

	// Offer one sample word, hold it until it is taken, then queue what the
	// block owes for it. A random gap may come first.
	task automatic push_sample(input sample_t s, input logic typed,
			input door_result_t typed_res);
		door_result_t predicted;

		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		yaw <= s.yaw;
		accel_x <= s.ax;
		accel_y <= s.ay;
		accel_z <= s.az;
		now_ticks <= s.now;
		session_end <= s.se;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = door_predict(s);
		expected_results.push_back(typed ? typed_res : predicted);
	endtask

	// One register write; the predictor copy follows only once it is taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_OPEN_YAW:      thr.open_yaw = data[THR_W-1:0];
			CFG_CLOSE_YAW:     thr.close_yaw = data[THR_W-1:0];
			CFG_STILL_YAW:     thr.still_yaw = data[THR_W-1:0];
			CFG_ACCEL_SQ_LOW:  thr.accel_sq_low = data;
			CFG_ACCEL_SQ_HIGH: thr.accel_sq_high = data;
			CFG_SETTLE_TICKS:  thr.settle_ticks = data;
			CFG_STATIC_NEEDED: thr.static_needed = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// pipeline fills and the block has to stall its input.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (hold_off_req) begin
			hold_off_req <= 1'b0;
			stall_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: every word taken is matched against the oldest expectation.
	always @(posedge clk) begin
		door_result_t want;

		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result word with nothing expected: state %0d opened %0b closed %0b",
					$time, door_status, opened_event, closed_event);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (door_status !== want.state) begin
					$display("%0t: door_status expected %0d actual %0d", $time, want.state,
						door_status);
					mismatch_count++;
				end
				if (opened_event !== want.opened) begin
					$display("%0t: opened_event expected %0b actual %0b", $time, want.opened,
						opened_event);
					mismatch_count++;
				end
				if (closed_event !== want.closed) begin
					$display("%0t: closed_event expected %0b actual %0b", $time, want.closed,
						closed_event);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		sample_t smp;
		motion_t motion;
		cfg_plan_t plan;
		int seg_left;
		int end_mode;
		int jitter;
		int roll;
		int cur_yaw;
		int y;
		logic first_in_seg;
		logic [TICK_W-1:0] cur_ticks;
		logic signed [ACC_W-1:0] tilt;
		logic [31:0] v_open, v_close, v_still, v_lo, v_hi, v_settle, v_static;
		logic [31:0] upper_junk;

		// Every input known from time zero, reset held low.
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		yaw <= '0;
		accel_x <= '0;
		accel_y <= '0;
		accel_z <= '0;
		now_ticks <= '0;
		session_end <= 1'b0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_OPEN_YAW;
		cfg_data <= '0;
		hold_off_req <= 1'b0;
		sink_idle_pct <= 20;
		src_idle_pct = 20;

		// Predictor starts from the reset state of the block.
		thr.open_yaw = RST_OPEN_YAW;
		thr.close_yaw = RST_CLOSE_YAW;
		thr.still_yaw = RST_STILL_YAW;
		thr.accel_sq_low = RST_ACCEL_SQ_LOW;
		thr.accel_sq_high = RST_ACCEL_SQ_HIGH;
		thr.settle_ticks = RST_SETTLE_TICKS;
		thr.static_needed = RST_STATIC_NEEDED;
		door_phase = PH_CLOSED;
		cand_ticks = '0;
		cand_yaw = '0;
		rest_run = '0;
		end_req = 1'b0;

		seg_left = 0;
		cur_yaw = 0;
		cur_ticks = 32'd5000;
		motion = SEG_CALM;
		end_mode = 3;
		jitter = 0;
		first_in_seg = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk under the reset thresholds.
		for (int i = 0; i < DIR_ROWS; i++)
			push_sample(DIR_TABLE[i].s, DIR_TABLE[i].typed, DIR_TABLE[i].r);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Thresholds change only with the block idle: every owed word back,
			// then the pipeline drained.
			in_valid <= 1'b0;
			while (expected_results.size() != 0)
				@(posedge clk);
			repeat (PIPE_DRAIN) @(posedge clk);

			plan = PHASE_PLAN[p];
			case (plan)
				PLAN_WANDER: begin
					v_open = $urandom_range(0, 4000);
					v_close = $urandom_range(0, v_open);
					v_still = $urandom_range(0, 120);
					v_lo = ONE_G_SQ - $urandom_range(0, 8000000);
					v_hi = ONE_G_SQ + $urandom_range(1, 8000000);
					v_settle = $urandom_range(0, 2000);
					v_static = $urandom_range(1, 63);
				end
				PLAN_GENTLE: begin
					// Short settle and a small count so closes happen often.
					v_open = RST_OPEN_YAW;
					v_close = RST_CLOSE_YAW;
					v_still = $urandom_range(36, 80);
					v_lo = RST_ACCEL_SQ_LOW;
					v_hi = RST_ACCEL_SQ_HIGH;
					v_settle = $urandom_range(0, 300);
					v_static = $urandom_range(1, 6);
				end
				PLAN_ALL_MAX: begin
					v_open = 32'h7FFF;
					v_close = 32'h7FFF;
					v_still = 32'h7FFF;
					v_lo = '0;
					v_hi = 32'hFFFF_FFFF;
					v_settle = 32'hFFFF_FFFF;
					v_static = 32'h3F;
				end
				PLAN_ALL_ZERO: begin
					// Empty window, nothing counts as still, and a zero count.
					v_open = '0;
					v_close = '0;
					v_still = '0;
					v_lo = '0;
					v_hi = '0;
					v_settle = '0;
					v_static = '0;
				end
				PLAN_EDGE_WINDOW: begin
					// Only exactly one g is at rest; anything else sits on or
					// beyond a bound.
					v_open = RST_OPEN_YAW;
					v_close = RST_CLOSE_YAW;
					v_still = 200;
					v_lo = ONE_G_SQ - 1;
					v_hi = ONE_G_SQ + 1;
					v_settle = $urandom_range(0, 50);
					v_static = 2;
				end
				PLAN_INVERTED: begin
					// Low bound at or above the high one: no sample is ever at rest.
					v_open = $urandom_range(0, 4000);
					v_close = $urandom_range(0, v_open);
					v_still = $urandom_range(0, 120);
					v_lo = ONE_G_SQ + $urandom_range(0, 4000000);
					v_hi = v_lo - $urandom_range(0, 4000000);
					v_settle = $urandom_range(0, 500);
					v_static = $urandom_range(1, 63);
				end
				default: begin
					// Zero count: the first at-rest sample after a request closes.
					v_open = RST_OPEN_YAW;
					v_close = RST_CLOSE_YAW;
					v_still = RST_STILL_YAW;
					v_lo = RST_ACCEL_SQ_LOW;
					v_hi = RST_ACCEL_SQ_HIGH;
					v_settle = 10;
					v_static = 0;
				end
			endcase

			// Narrow registers sometimes get junk above their width, which the
			// block must drop.
			upper_junk = $urandom_range(0, 1) ? $urandom : 32'd0;
			write_reg(CFG_UNUSED_IDX, $urandom);
			write_reg(CFG_OPEN_YAW, v_open | (upper_junk & ~32'h7FFF));
			write_reg(CFG_CLOSE_YAW, v_close | (upper_junk & ~32'h7FFF));
			write_reg(CFG_STILL_YAW, v_still | (upper_junk & ~32'h7FFF));
			write_reg(CFG_ACCEL_SQ_LOW, v_lo);
			write_reg(CFG_ACCEL_SQ_HIGH, v_hi);
			write_reg(CFG_SETTLE_TICKS, v_settle);
			write_reg(CFG_STATIC_NEEDED, v_static | (upper_junk & ~32'h3F));
			cfg_valid <= 1'b0;

			// The closing phases run with no idling on either side.
			if (p >= NUM_PHASES - 2) begin
				src_idle_pct = 0;
				sink_idle_pct <= 0;
			end else begin
				src_idle_pct = $urandom_range(0, 40);
				sink_idle_pct <= $urandom_range(0, 40);
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 1 && n == 10)
					hold_off_req <= 1'b1;

				// Samples come in segments of one kind of motion. Calm stretches
				// let candidates settle and session-end counts build up; swings
				// cross the yaw thresholds; bumps and raw noise break things up.
				first_in_seg = 1'b0;
				if (seg_left == 0) begin
					roll = $urandom_range(0, 99);
					if (roll < 45) begin
						motion = SEG_CALM;
						seg_left = $urandom_range(5, 70);
					end else if (roll < 80) begin
						motion = SEG_SWING;
						seg_left = $urandom_range(3, 20);
					end else if (roll < 92) begin
						motion = SEG_BUMPY;
						seg_left = $urandom_range(1, 6);
					end else begin
						motion = SEG_NOISE;
						seg_left = $urandom_range(1, 4);
					end
					end_mode = $urandom_range(0, 3);
					jitter = $urandom_range(0, 40);
					first_in_seg = 1'b1;
					if ($urandom_range(0, 19) == 0)
						cur_ticks = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				end
				seg_left--;

				cur_ticks = cur_ticks + $urandom_range(1, 300);
				if ($urandom_range(0, 63) == 0)
					cur_ticks = $urandom;

				// Accelerometer at rest: exactly one g on one axis, or close to it.
				if ($urandom_range(0, 1)) begin
					smp.ax = '0;
					smp.ay = '0;
					smp.az = '0;
					tilt = $urandom_range(0, 1) ? ONE_G : -ONE_G;
					case ($urandom_range(0, 2))
						0: smp.ax = tilt;
						1: smp.ay = tilt;
						default: smp.az = tilt;
					endcase
				end else begin
					smp.ax = 16'(int'(ONE_G) + int'($urandom_range(0, 600)) - 300);
					smp.ay = 16'(int'($urandom_range(0, 600)) - 300);
					smp.az = 16'(int'($urandom_range(0, 600)) - 300);
				end

				y = cur_yaw;
				case (motion)
					SEG_CALM: begin
						y = cur_yaw + int'($urandom_range(0, 2 * jitter)) - jitter;
					end
					SEG_SWING: begin
						if ($urandom_range(0, 2) == 0) begin
							case ($urandom_range(0, 5))
								0: cur_yaw = int'(thr.open_yaw) + int'($urandom_range(1, 400));
								1: cur_yaw = int'(thr.close_yaw) - int'($urandom_range(1, 400));
								2: cur_yaw = int'(thr.open_yaw);
								3: cur_yaw = int'(thr.close_yaw) + ($urandom_range(0, 1) ? 1 : -1);
								4: cur_yaw = int'($urandom_range(0, 10000)) - 4000;
								default: cur_yaw = int'(thr.close_yaw) - int'($urandom_range(0, 400));
							endcase
						end
						y = cur_yaw + int'($urandom_range(0, 10)) - 5;
						if ($urandom_range(0, 3) == 0) begin
							smp.ax = 16'(int'($urandom_range(0, 40000)) - 20000);
							smp.ay = 16'(int'($urandom_range(0, 40000)) - 20000);
						end
					end
					SEG_BUMPY: begin
						smp.ax = 16'(int'($urandom_range(0, 40000)) - 20000);
						smp.ay = 16'(int'($urandom_range(0, 40000)) - 20000);
						smp.az = 16'(int'($urandom_range(0, 40000)) - 20000);
						y = cur_yaw + int'($urandom_range(0, 200)) - 100;
					end
					default: ;
				endcase
				if (y > 32767)
					y = 32767;
				if (y < -32768)
					y = -32768;
				smp.yaw = 16'(y);
				smp.now = cur_ticks;
				// A one-sample pulse at the start of the segment, or held throughout.
				smp.se = (end_mode == 1) || (end_mode == 0 && first_in_seg);

				if (motion == SEG_NOISE)
					smp = sample_t'(SAMPLE_W'({$urandom, $urandom, $urandom, $urandom}));

				push_sample(smp, 1'b0, '0);
			end
		end

		// All stimulus taken: wait for the last words and let the pipeline empty.
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
src/dod_pkg.sv
src/dod_cfg.sv
src/dod_mag.sv
src/dod_fsm.sv
src/door_open_close_detector_top.sv
verif/door_open_close_detector_top_tb.sv
